>>> rtl/mfpf_pkg.sv
// ----------------------------------------------------------------------------
// mfpf_pkg
// Shared sizes, types and constants for the matched filter peak finder.
// ----------------------------------------------------------------------------
package mfpf_pkg;

  localparam int Taps      = 32;
  localparam int RecordLen = 1024;

  localparam int SampleW   = 14;
  localparam int CoeffW    = 16;
  localparam int CoefIdxW  = 6;
  localparam int ProdW     = SampleW + CoeffW;
  localparam int AccW      = 36;
  localparam int PeakW     = 35;
  localparam int PosW      = 10;
  localparam int TapCfgW   = 7;

  // tap count in use (1..Taps), shift distance (0..Taps-1)
  localparam int TapsCntW  = $clog2(Taps + 1);
  localparam int StepW     = $clog2(Taps);
  localparam int CountW    = $clog2(RecordLen + 1);

  localparam logic [TapCfgW-1:0] TapCountRst = TapCfgW'(32);

  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncSample = 1'b1;

  // per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic clear;   // zero the sample window
    logic shift;   // shift a new sample into the window
    logic copy;    // window -> working chain
    logic wshift;  // working chain moves one cell down
    logic mul;     // register the cell products
    logic sum;     // partial sums advance one cell
    logic coef_we; // coefficient load
  } mfpf_ctl_t;

endpackage

>>> rtl/mfpf_cell.sv
// ----------------------------------------------------------------------------
// mfpf_cell
// One tap: window sample, working sample, coefficient, product, partial sum.
// ----------------------------------------------------------------------------
module mfpf_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mfpf_pkg::mfpf_ctl_t                  ctl_i,
  input  logic                                 tap_active_i,
  input  logic                                 coef_sel_i,
  input  logic signed [mfpf_pkg::CoeffW-1:0]   coef_val_i,
  input  logic signed [mfpf_pkg::SampleW-1:0]  win_i,
  output logic signed [mfpf_pkg::SampleW-1:0]  win_o,
  input  logic signed [mfpf_pkg::SampleW-1:0]  wrk_i,
  output logic signed [mfpf_pkg::SampleW-1:0]  wrk_o,
  input  logic signed [mfpf_pkg::AccW-1:0]     psum_i,
  output logic signed [mfpf_pkg::AccW-1:0]     psum_o
);

  logic signed [mfpf_pkg::SampleW-1:0] win_q;
  logic signed [mfpf_pkg::SampleW-1:0] wrk_q;
  logic signed [mfpf_pkg::CoeffW-1:0]  coef_q;
  logic signed [mfpf_pkg::ProdW-1:0]   prod_q;
  logic signed [mfpf_pkg::AccW-1:0]    psum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (ctl_i.clear) begin
      win_q <= '0;
    end else if (ctl_i.shift) begin
      win_q <= win_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.copy) begin
      wrk_q <= win_q;
    end else if (ctl_i.wshift) begin
      wrk_q <= wrk_i;
    end
    if (ctl_i.coef_we && coef_sel_i) begin
      coef_q <= coef_val_i;
    end
    // unused taps contribute nothing, even if never loaded
    if (ctl_i.mul) begin
      if (tap_active_i) begin
        prod_q <= wrk_q * coef_q;
      end else begin
        prod_q <= '0;
      end
    end
    if (ctl_i.sum) begin
      psum_q <= psum_i + mfpf_pkg::AccW'(prod_q);
    end
  end

  assign win_o  = win_q;
  assign wrk_o  = wrk_q;
  assign psum_o = psum_q;

endmodule

>>> rtl/mfpf_chain.sv
// ----------------------------------------------------------------------------
// mfpf_chain
// Row of tap cells. Samples enter at the top cell and move down; partial
// sums start at cell 0 and move up to the top cell.
// ----------------------------------------------------------------------------
module mfpf_chain (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mfpf_pkg::mfpf_ctl_t                  ctl_i,
  input  logic [mfpf_pkg::TapsCntW-1:0]        taps_i,
  input  logic [mfpf_pkg::CoefIdxW-1:0]        coef_idx_i,
  input  logic signed [mfpf_pkg::CoeffW-1:0]   coef_val_i,
  input  logic signed [mfpf_pkg::SampleW-1:0]  sample_i,
  output logic signed [mfpf_pkg::AccW-1:0]     sum_o
);

  logic signed [mfpf_pkg::SampleW-1:0] win_in  [mfpf_pkg::Taps];
  logic signed [mfpf_pkg::SampleW-1:0] win_out [mfpf_pkg::Taps];
  logic signed [mfpf_pkg::SampleW-1:0] wrk_in  [mfpf_pkg::Taps];
  logic signed [mfpf_pkg::SampleW-1:0] wrk_out [mfpf_pkg::Taps];
  logic signed [mfpf_pkg::AccW-1:0]    ps_in   [mfpf_pkg::Taps];
  logic signed [mfpf_pkg::AccW-1:0]    ps_out  [mfpf_pkg::Taps];

  for (genvar j = 0; j < mfpf_pkg::Taps; j++) begin : g_cell
    if (j == mfpf_pkg::Taps - 1) begin : g_top
      assign win_in[j] = sample_i;
      assign wrk_in[j] = '0;
    end else begin : g_mid
      assign win_in[j] = win_out[j+1];
      assign wrk_in[j] = wrk_out[j+1];
    end
    if (j == 0) begin : g_first
      assign ps_in[j] = '0;
    end else begin : g_next
      assign ps_in[j] = ps_out[j-1];
    end

    mfpf_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl_i),
      .tap_active_i(mfpf_pkg::TapsCntW'(j) < taps_i),
      .coef_sel_i  (coef_idx_i == mfpf_pkg::CoefIdxW'(j)),
      .coef_val_i  (coef_val_i),
      .win_i       (win_in[j]),
      .win_o       (win_out[j]),
      .wrk_i       (wrk_in[j]),
      .wrk_o       (wrk_out[j]),
      .psum_i      (ps_in[j]),
      .psum_o      (ps_out[j])
    );
  end

  assign sum_o = ps_out[mfpf_pkg::Taps-1];

endmodule

>>> rtl/matched_filter_peak_finder.sv
// ----------------------------------------------------------------------------
// matched_filter_peak_finder
// Correlates a loaded template against a sample record and tracks the peak.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i / in_stall_o) takes coefficient loads
// (func_i = 0) and samples (func_i = 1). A load finishes in its own cycle and
// yields nothing. A sample that completes a window, or carries last_sample_i,
// yields one request on the output channel (out_valid_o / out_stall_i); the
// last sample also reports the record peak and restarts the record.
// The user writes tap_count (cfg_we_i / cfg_wdata_i) only while idle; not enforced.
// Sequence: a sample with a window goes through a copy of the window into
// the working chain, an alignment shift of the working chain down by
// Taps - n cells (n = taps in use, Taps = 32), a multiply step, the partial
// sums rippling up the whole tap chain, and a step into the output register.
// A sample without a window returns to idle, or, with last_sample_i, goes
// straight to the output step. in_stall_o is high for the whole of this work.
// Reset clears the window, the record, the peak and sets tap_count to 32; the
// template is undefined until loaded. While the receiver stalls, the result
// register holds; a sample is still taken, but its result waits, stalling input.
// ----------------------------------------------------------------------------
module matched_filter_peak_finder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mfpf_pkg::TapCfgW-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [mfpf_pkg::CoefIdxW-1:0]       coeff_index_i,
  input  logic signed [mfpf_pkg::CoeffW-1:0]  coeff_value_i,
  input  logic signed [mfpf_pkg::SampleW-1:0] sample_value_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                filt_valid_o,
  output logic signed [mfpf_pkg::AccW-1:0]    filt_value_o,
  output logic [mfpf_pkg::PosW-1:0]           filt_index_o,
  output logic                                record_done_o,
  output logic [mfpf_pkg::PeakW-1:0]          peak_value_o,
  output logic [mfpf_pkg::PosW-1:0]           peak_index_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COPY  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_MUL   = 6'b001000,
    S_SUM   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [mfpf_pkg::TapCfgW-1:0]  tap_count_q;
  logic [mfpf_pkg::TapsCntW-1:0] taps_n;
  logic [mfpf_pkg::CountW-1:0]   count_q, count_d, count_inc;
  logic [mfpf_pkg::StepW-1:0]    cnt_q, cnt_d;
  logic [mfpf_pkg::StepW-1:0]    dist_q, dist_d;
  logic [mfpf_pkg::PosW-1:0]     pos_q, pos_d;
  logic                          win_q, win_d;
  logic                          last_q, last_d;
  logic signed [mfpf_pkg::AccW-1:0] best_q, best_d, best_upd;
  logic [mfpf_pkg::PosW-1:0]     best_pos_q, best_pos_d, best_pos_upd;

  logic                          out_valid_q, out_valid_d;
  logic                          ofv_q;
  logic signed [mfpf_pkg::AccW-1:0] ofval_q;
  logic [mfpf_pkg::PosW-1:0]     ofidx_q;
  logic                          odone_q;
  logic [mfpf_pkg::PeakW-1:0]    opeak_q;
  logic [mfpf_pkg::PosW-1:0]     opidx_q;

  logic                          accept, room, out_load, has_win;
  logic signed [mfpf_pkg::AccW-1:0] sum;
  mfpf_pkg::mfpf_ctl_t           ctl;

  // taps in use: 0 counts as 1, anything above Taps as Taps
  always_comb begin
    if (tap_count_q == '0) begin
      taps_n = mfpf_pkg::TapsCntW'(1);
    end else if (tap_count_q > mfpf_pkg::TapCfgW'(mfpf_pkg::Taps)) begin
      taps_n = mfpf_pkg::TapsCntW'(mfpf_pkg::Taps);
    end else begin
      taps_n = mfpf_pkg::TapsCntW'(tap_count_q);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign room       = (count_q < mfpf_pkg::CountW'(mfpf_pkg::RecordLen));
  assign count_inc  = count_q + mfpf_pkg::CountW'(1);
  assign has_win    = room && (count_inc >= mfpf_pkg::CountW'(taps_n));
  assign out_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    if (win_q && (sum > best_q)) begin
      best_upd     = sum;
      best_pos_upd = pos_q;
    end else begin
      best_upd     = best_q;
      best_pos_upd = best_pos_q;
    end
  end

  always_comb begin
    ctl         = '0;
    ctl.coef_we = accept && (func_i == mfpf_pkg::FuncLoad);
    ctl.shift   = accept && (func_i == mfpf_pkg::FuncSample) && room;
    ctl.copy    = (state_q == S_COPY);
    ctl.wshift  = (state_q == S_SHIFT);
    ctl.mul     = (state_q == S_MUL);
    ctl.sum     = (state_q == S_SUM);
    ctl.clear   = out_load && last_q;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    cnt_d      = cnt_q;
    dist_d     = dist_q;
    pos_d      = pos_q;
    win_d      = win_q;
    last_d     = last_q;
    best_d     = best_q;
    best_pos_d = best_pos_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (func_i == mfpf_pkg::FuncSample)) begin
          if (room) begin
            count_d = count_inc;
          end
          win_d  = has_win;
          last_d = last_sample_i;
          dist_d = mfpf_pkg::StepW'(mfpf_pkg::TapsCntW'(mfpf_pkg::Taps) - taps_n);
          pos_d  = mfpf_pkg::PosW'(count_inc - mfpf_pkg::CountW'(taps_n));
          if (has_win) begin
            state_d = S_COPY;
          end else if (last_sample_i) begin
            state_d = S_FIN;
          end
        end
      end
      S_COPY: begin
        cnt_d   = '0;
        state_d = (dist_q == '0) ? S_MUL : S_SHIFT;
      end
      S_SHIFT: begin
        cnt_d = cnt_q + mfpf_pkg::StepW'(1);
        if (cnt_q == dist_q - mfpf_pkg::StepW'(1)) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cnt_d   = '0;
        state_d = S_SUM;
      end
      S_SUM: begin
        cnt_d = cnt_q + mfpf_pkg::StepW'(1);
        if (cnt_q == mfpf_pkg::StepW'(mfpf_pkg::Taps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
          if (last_q) begin
            count_d    = '0;
            best_d     = '0;
            best_pos_d = '0;
          end else begin
            best_d     = best_upd;
            best_pos_d = best_pos_upd;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_count_q <= mfpf_pkg::TapCountRst;
      count_q     <= '0;
      cnt_q       <= '0;
      dist_q      <= '0;
      win_q       <= 1'b0;
      last_q      <= 1'b0;
      best_q      <= '0;
      best_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        tap_count_q <= cfg_wdata_i;
      end
      count_q     <= count_d;
      cnt_q       <= cnt_d;
      dist_q      <= dist_d;
      win_q       <= win_d;
      last_q      <= last_d;
      best_q      <= best_d;
      best_pos_q  <= best_pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (out_load) begin
      ofv_q   <= win_q;
      ofval_q <= win_q ? sum : '0;
      ofidx_q <= win_q ? pos_q : '0;
      odone_q <= last_q;
      opeak_q <= last_q ? mfpf_pkg::PeakW'(best_upd) : '0;
      opidx_q <= last_q ? best_pos_upd : '0;
    end
  end

  mfpf_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .taps_i    (taps_n),
    .coef_idx_i(coeff_index_i),
    .coef_val_i(coeff_value_i),
    .sample_i  (sample_value_i),
    .sum_o     (sum)
  );

  assign out_valid_o   = out_valid_q;
  assign filt_valid_o  = ofv_q;
  assign filt_value_o  = ofval_q;
  assign filt_index_o  = ofidx_q;
  assign record_done_o = odone_q;
  assign peak_value_o  = opeak_q;
  assign peak_index_o  = opidx_q;

endmodule
